// File: hdl/drrip_pkg.sv
// shared constants, field widths and register indexes for the drrip replacement unit
// no dependencies; compiled first
package drrip_pkg;

	// default geometry
	localparam int NUM_SETS_DEF       = 2048;
	localparam int NUM_WAYS_DEF       = 16;
	localparam int LEADER_SETS_DEF    = 64;
	localparam int SELECTOR_WIDTH_DEF = 10;
	localparam int PRIORITY_WIDTH_DEF = 2;

	// fixed field widths of the request and response
	localparam int SET_IN_W  = 11;
	localparam int WAY_IN_W  = 4;
	localparam int VICTIM_W  = 4;
	localparam int INS_W     = 2;
	localparam int SEL_OUT_W = 10;
	localparam int REUSE_W   = 2;
	localparam int CNT_W     = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int INSERT_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SRRIP_INSERT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRRIP_INSERT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 2'd2;

	// register reset values
	localparam logic [INSERT_W-1:0] SRRIP_INSERT_RST = 2'd1;
	localparam logic [INSERT_W-1:0] BRRIP_INSERT_RST = 2'd3;
	localparam logic [CNT_W-1:0]    DECAY_PERIOD_RST = 16'd8192;

	// request actions
	localparam logic ACT_VICTIM = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

endpackage

// File: hdl/drrip_if.sv
// request and response channels of the drrip replacement unit
// depends on drrip_pkg
interface drrip_req_if
	import drrip_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic                action;
	logic [SET_IN_W-1:0] set_index;
	logic [WAY_IN_W-1:0] way;
	logic                hit;

	modport source (output valid, action, set_index, way, hit, input ready);
	modport sink   (input valid, action, set_index, way, hit, output ready);
endinterface

interface drrip_rsp_if
	import drrip_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [VICTIM_W-1:0]  victim_way;
	logic [INS_W-1:0]     inserted_priority;
	logic [SEL_OUT_W-1:0] selector_value;

	modport source (output valid, victim_way, inserted_priority, selector_value, input ready);
	modport sink   (input valid, victim_way, inserted_priority, selector_value, output ready);
endinterface

// File: hdl/drrip_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// depends on drrip_pkg for default sizes
module drrip_ram
	import drrip_pkg::*;
#(
	parameter int WIDTH = NUM_WAYS_DEF * (PRIORITY_WIDTH_DEF + REUSE_W),
	parameter int DEPTH = NUM_SETS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/drrip_dead_block_replacement_unit.sv
// top level of the drrip replacement unit with reuse-based dead block insertion
// depends on drrip_pkg, drrip_if and drrip_ram
//
// Each request passes through the idle, calc and write states: it is taken in the idle state,
// which also reads its set line from the line memory, the calc state finds the highest
// re-reference value in the line, and the write state writes the modified line back and loads
// the response register (it waits there only while an earlier response is still untaken).
// The memory holds one line per set with all ways' re-reference values and reuse counters, so
// one read and one write per request set the rate. An update that completes a decay period
// first walks the whole memory halving reuse counters, then rereads its own set line. After
// reset the same walk fills the memory with its reset contents, during which no request is
// taken; configuration writes are taken at any time.
module drrip_dead_block_replacement_unit
	import drrip_pkg::*;
#(
	parameter int NUM_SETS       = NUM_SETS_DEF,
	parameter int NUM_WAYS       = NUM_WAYS_DEF,
	parameter int LEADER_SETS    = LEADER_SETS_DEF,
	parameter int SELECTOR_WIDTH = SELECTOR_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	drrip_req_if.sink             req,
	drrip_rsp_if.source           rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int WAY_W  = $clog2(NUM_WAYS);
	localparam int PW     = PRIORITY_WIDTH;
	localparam int SW     = SELECTOR_WIDTH;
	localparam int RLEV   = 1 << PW;
	localparam int LINE_W = NUM_WAYS * (PW + REUSE_W);

	localparam logic [PW-1:0]      RMAX      = {PW{1'b1}};
	localparam logic [SW-1:0]      SEL_MAX   = {SW{1'b1}};
	localparam logic [SW-1:0]      SEL_MID   = {1'b0, {(SW - 1){1'b1}}};
	localparam logic [REUSE_W-1:0] REUSE_TOP = {REUSE_W{1'b1}};
	localparam logic [SET_W-1:0]   SET_LAST  = SET_W'(NUM_SETS - 1);
	localparam logic [LINE_W-1:0]  LINE_RST  = {{(NUM_WAYS * REUSE_W){1'b0}},
		{(NUM_WAYS * PW){1'b1}}};

	// control states
	localparam logic [2:0] ST_SWEEP  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CALC   = 3'd2;
	localparam logic [2:0] ST_WRITE  = 3'd3;
	localparam logic [2:0] ST_REREAD = 3'd4;

	// set index reduced modulo the set count, quotient is at most seven
	function automatic logic [SET_W-1:0] set_mod(input logic [SET_IN_W-1:0] s);
		logic [SET_IN_W-1:0] v;
		v = s;
		for (int k = 2; k >= 0; k--) begin
			if (int'(v) >= (NUM_SETS << k)) begin
				v = v - SET_IN_W'(NUM_SETS << k);
			end
		end
		return SET_W'(v);
	endfunction

	logic [2:0]          state_q;
	logic                clear_q;
	logic [SET_W-1:0]    sw_q;
	logic                sw_rd_q;
	logic                sw_v_s1;
	logic [SET_W-1:0]    sw_addr_s1;

	logic                act_q;
	logic [SET_W-1:0]    set_q;
	logic [WAY_W-1:0]    way_q;
	logic                way_ok_q;
	logic                hit_q;

	logic [INSERT_W-1:0] srrip_q;
	logic [INSERT_W-1:0] brrip_q;
	logic [CNT_W-1:0]    period_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_nx;
	logic [SW-1:0]       sel_q;
	logic [SW-1:0]       sel_nx;

	logic [LINE_W-1:0]   line_s2;
	logic [PW-1:0]       top_s2;

	logic                rsp_v_q;
	logic [VICTIM_W-1:0] victim_q;
	logic [INS_W-1:0]    ins_q;

	logic                ram_we;
	logic [SET_W-1:0]    ram_waddr;
	logic [LINE_W-1:0]   ram_wdata;
	logic [SET_W-1:0]    ram_raddr;
	logic [LINE_W-1:0]   ram_rdata;

	logic [NUM_WAYS-1:0][REUSE_W-1:0] rd_reuse;
	logic [NUM_WAYS-1:0][PW-1:0]      rd_rrpv;
	logic [NUM_WAYS-1:0][REUSE_W-1:0] reuse_cur;
	logic [NUM_WAYS-1:0][PW-1:0]      rrpv_cur;
	logic [NUM_WAYS-1:0][REUSE_W-1:0] reuse_new;
	logic [NUM_WAYS-1:0][PW-1:0]      rrpv_new;
	logic [NUM_WAYS-1:0][REUSE_W-1:0] reuse_half;
	logic [RLEV-1:0]                  lvl;
	logic [PW-1:0]                    top_rd;
	logic [PW-1:0]                    lift;
	logic [WAY_W-1:0]                 victim;
	logic [PW-1:0]                    ins;
	logic [REUSE_W-1:0]               old_reuse;
	logic                             lead_s;
	logic                             lead_b;
	logic                             req_fire;
	logic                             wr_go;
	logic                             decay_hit;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign wr_go     = (state_q == ST_WRITE) && (!rsp_v_q || rsp.ready);
	assign cnt_nx    = cnt_q + CNT_W'(1);
	assign decay_hit = (cnt_nx == period_q);

	assign rsp.valid             = rsp_v_q;
	assign rsp.victim_way        = victim_q;
	assign rsp.inserted_priority = ins_q;
	assign rsp.selector_value    = SEL_OUT_W'(sel_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srrip_q  <= SRRIP_INSERT_RST;
			brrip_q  <= BRRIP_INSERT_RST;
			period_q <= DECAY_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRRIP_INSERT: srrip_q  <= cfg_data[INSERT_W-1:0];
				CFG_BRRIP_INSERT: brrip_q  <= cfg_data[INSERT_W-1:0];
				CFG_DECAY_PERIOD: period_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// line memory
	drrip_ram #(
		.WIDTH (LINE_W),
		.DEPTH (NUM_SETS)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read address select
	always_comb begin
		unique case (state_q)
			ST_SWEEP:  ram_raddr = sw_q;
			ST_REREAD: ram_raddr = set_q;
			default:   ram_raddr = set_mod(req.set_index);
		endcase
	end

	// split the line just read and halve its reuse counters for a decay sweep
	assign {rd_reuse, rd_rrpv} = ram_rdata;
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			reuse_half[w] = rd_reuse[w] >> 1;
		end
	end

	// highest re-reference value present in the line just read
	always_comb begin
		lvl    = '0;
		top_rd = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			lvl[rd_rrpv[w]] = 1'b1;
		end
		for (int v = 0; v < RLEV; v++) begin
			if (lvl[v]) begin
				top_rd = PW'(v);
			end
		end
	end

	// write port select: sweep writes or request write-back
	always_comb begin
		if (state_q == ST_SWEEP) begin
			ram_we    = sw_v_s1;
			ram_waddr = sw_addr_s1;
			ram_wdata = clear_q ? LINE_RST : {reuse_half, rd_rrpv};
		end else begin
			ram_we    = wr_go;
			ram_waddr = set_q;
			ram_wdata = {reuse_new, rrpv_new};
		end
	end

	// modify the line held in the second stage
	assign {reuse_cur, rrpv_cur} = line_s2;
	assign lead_s = int'(set_q) < LEADER_SETS;
	assign lead_b = !lead_s && (int'(set_q) < 2 * LEADER_SETS);
	assign lift   = RMAX - top_s2;

	always_comb begin
		rrpv_new  = rrpv_cur;
		reuse_new = reuse_cur;
		victim    = '0;
		ins       = '0;
		sel_nx    = sel_q;
		old_reuse = reuse_cur[way_q];
		if (act_q == ACT_VICTIM) begin
			// age the set so its top reaches the maximum, lowest such way is the victim
			for (int w = 0; w < NUM_WAYS; w++) begin
				rrpv_new[w] = rrpv_cur[w] + lift;
			end
			for (int w = NUM_WAYS - 1; w >= 0; w--) begin
				if (rrpv_cur[w] == top_s2) begin
					victim = WAY_W'(w);
				end
			end
		end else if (way_ok_q) begin
			if (hit_q) begin
				rrpv_new[way_q] = '0;
				if (old_reuse != REUSE_TOP) begin
					reuse_new[way_q] = old_reuse + REUSE_W'(1);
				end
				priority if (lead_s) begin
					if (sel_q != SEL_MAX) begin
						sel_nx = sel_q + SW'(1);
					end
				end else if (lead_b) begin
					if (sel_q != '0) begin
						sel_nx = sel_q - SW'(1);
					end
				end else begin
					// followers leave the selector alone
					sel_nx = sel_q;
				end
			end else begin
				// dueling choice, then overridden by the old reuse count
				priority if (lead_s) begin
					ins = PW'(srrip_q);
				end else if (lead_b) begin
					ins = PW'(brrip_q);
				end else if (sel_q >= SEL_MID) begin
					ins = PW'(srrip_q);
				end else begin
					ins = PW'(brrip_q);
				end
				if (old_reuse == '0) begin
					ins = RMAX;
				end else if (old_reuse >= REUSE_W'(2)) begin
					ins = '0;
				end
				rrpv_new[way_q]  = ins;
				reuse_new[way_q] = '0;
			end
		end
	end

	// request capture and stage registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			act_q    <= req.action;
			set_q    <= set_mod(req.set_index);
			way_q    <= WAY_W'(req.way);
			way_ok_q <= int'(req.way) < NUM_WAYS;
			hit_q    <= req.hit;
		end
		if (state_q == ST_CALC) begin
			line_s2 <= ram_rdata;
			top_s2  <= top_rd;
		end
		if (state_q == ST_SWEEP) begin
			sw_addr_s1 <= sw_q;
		end
		if (wr_go) begin
			victim_q <= VICTIM_W'(victim);
			ins_q    <= INS_W'(ins);
		end
	end

	// control: sequencer, sweep, access counter, selector and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			clear_q <= 1'b1;
			sw_q    <= '0;
			sw_rd_q <= 1'b1;
			sw_v_s1 <= 1'b0;
			cnt_q   <= '0;
			sel_q   <= SEL_MID;
			rsp_v_q <= 1'b0;
		end else begin
			if (wr_go) begin
				rsp_v_q <= 1'b1;
				sel_q   <= sel_nx;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: begin
					sw_v_s1 <= sw_rd_q;
					if (sw_rd_q) begin
						if (sw_q == SET_LAST) begin
							sw_rd_q <= 1'b0;
						end else begin
							sw_q <= sw_q + SET_W'(1);
						end
					end else if (sw_v_s1) begin
						clear_q <= 1'b0;
						state_q <= clear_q ? ST_IDLE : ST_REREAD;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						if (req.action == ACT_UPDATE && decay_hit) begin
							cnt_q   <= '0;
							sw_q    <= '0;
							sw_rd_q <= 1'b1;
							state_q <= ST_SWEEP;
						end else begin
							if (req.action == ACT_UPDATE) begin
								cnt_q <= cnt_nx;
							end
							state_q <= ST_CALC;
						end
					end
				end
				ST_REREAD: state_q <= ST_CALC;
				ST_CALC:   state_q <= ST_WRITE;
				ST_WRITE: begin
					if (wr_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
